@@ rtl/vbr_pkg.sv @@
// ----------------------------------------------------------------------------
// vbr_pkg
// Shared types for the vertex bounds and radius block: the status of the
// set queue and the state encoding of the square root back end.
// ----------------------------------------------------------------------------
package vbr_pkg;

    // Occupancy flags of the queue that sits between front and back end.
    typedef struct packed {
        logic full;
        logic not_empty;
    } vbr_q_status_t;

    // Square root back end: wait for a set, iterate, hand over the result.
    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_RUN  = 3'b010,
        BK_HOLD = 3'b100
    } vbr_back_state_t;

endpackage

@@ rtl/vertex_bounds_and_radius.sv @@
// ----------------------------------------------------------------------------
// vertex_bounds_and_radius
// Axis-aligned bounding box and bounding radius of a vertex stream.
// ----------------------------------------------------------------------------
// Usage: vertex beats enter on the in channel (in_valid / in_stall) with
// coordinates in signed fixed point and set markers. Each beat marked last,
// and each empty-set beat, yields one result beat on the out channel
// (out_valid / out_stall) carrying the box and the floor square root of
// the largest squared length.
// Throughput: one vertex beat per cycle while in_stall is low. The square
// root unit resolves one radius bit per cycle and works on one set at a
// time; a two-entry queue holds finished sets while it works, and sets
// closing faster than the unit finishes them stall the in channel.
// Result path of a closing beat: the stage 1 register, the queue write,
// the pop, COORD_WIDTH root steps and the handover into the result register.
// Reset: the stored box and squared maximum clear to zero, all channels go
// empty. A stalled result holds on the outputs; the back end keeps working
// on the next set and the front end keeps taking vertices until the queue
// is full.
// ----------------------------------------------------------------------------
module vertex_bounds_and_radius
    import vbr_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    input  logic                          first_vertex,
    input  logic                          last_vertex,
    input  logic                          extend_only,
    input  logic                          empty_set,
    input  logic                          in_valid,
    output logic                          in_stall,
    output logic signed [COORD_WIDTH-1:0] min_x,
    output logic signed [COORD_WIDTH-1:0] min_y,
    output logic signed [COORD_WIDTH-1:0] min_z,
    output logic signed [COORD_WIDTH-1:0] max_x,
    output logic signed [COORD_WIDTH-1:0] max_y,
    output logic signed [COORD_WIDTH-1:0] max_z,
    output logic [COORD_WIDTH-1:0]        radius,
    output logic                          out_valid,
    input  logic                          out_stall
);

    localparam int JOB_W = 8 * COORD_WIDTH;

    logic             push, pop;
    logic [JOB_W-1:0] push_data, pop_data;
    vbr_q_status_t    q_status;

    // Accumulating front end.
    vbr_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .first_vertex (first_vertex),
        .last_vertex  (last_vertex),
        .extend_only  (extend_only),
        .empty_set    (empty_set),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .push         (push),
        .push_data    (push_data),
        .q_status     (q_status)
    );

    // Finished sets waiting for the root unit.
    vbr_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    // Square root back end and result register.
    vbr_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_data  (pop_data),
        .pop       (pop),
        .min_x     (min_x),
        .min_y     (min_y),
        .min_z     (min_z),
        .max_x     (max_x),
        .max_y     (max_y),
        .max_z     (max_z),
        .radius    (radius),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

@@ rtl/vbr_front.sv @@
// ----------------------------------------------------------------------------
// vbr_front
// Accepts vertex beats, squares the coordinates in a first stage and folds
// the vertex into the stored box and squared maximum in a second stage.
// Each finished set is pushed to the queue as box plus squared maximum.
// ----------------------------------------------------------------------------
module vbr_front
    import vbr_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    input  logic                          first_vertex,
    input  logic                          last_vertex,
    input  logic                          extend_only,
    input  logic                          empty_set,
    input  logic                          in_valid,
    output logic                          in_stall,
    output logic                          push,
    output logic [8*COORD_WIDTH-1:0]      push_data,
    input  vbr_q_status_t                 q_status
);

    localparam int CW   = COORD_WIDTH;
    localparam int SQ_W = 2 * COORD_WIDTH;

    // Stage 1 registers.
    logic                 s1_valid_reg, s1_valid_next;
    logic signed [CW-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic signed [CW-1:0] s1_x_next, s1_y_next, s1_z_next;
    logic [SQ_W-1:0]      s1_sqx_reg, s1_sqy_reg, s1_sqz_reg;
    logic [SQ_W-1:0]      s1_sqx_next, s1_sqy_next, s1_sqz_next;
    logic                 s1_first_reg, s1_last_reg, s1_extend_reg, s1_empty_reg;
    logic                 s1_first_next, s1_last_next, s1_extend_next, s1_empty_next;

    // Accumulated set state.
    logic signed [CW-1:0] low_x_reg, low_y_reg, low_z_reg;
    logic signed [CW-1:0] high_x_reg, high_y_reg, high_z_reg;
    logic signed [CW-1:0] low_x_next, low_y_next, low_z_next;
    logic signed [CW-1:0] high_x_next, high_y_next, high_z_next;
    logic [SQ_W-1:0]      max_sq_reg, max_sq_next;

    logic [CW-1:0]        abs_x, abs_y, abs_z;
    logic                 accept, advance, emit;
    logic                 restart;
    logic signed [CW-1:0] base_lx, base_ly, base_lz, base_hx, base_hy, base_hz;
    logic [SQ_W-1:0]      base_sq, sq_sum;

    // Handshake: stage 2 only blocks when it must push into a full queue.
    assign emit     = s1_empty_reg || s1_last_reg;
    assign in_stall = s1_valid_reg && emit && q_status.full;
    assign advance  = s1_valid_reg && !(emit && q_status.full);
    assign accept   = in_valid && !in_stall;

    // Stage 1: magnitudes and their squares.
    always_comb
    begin
        abs_x = pos_x[CW-1] ? CW'(-pos_x) : CW'(pos_x);
        abs_y = pos_y[CW-1] ? CW'(-pos_y) : CW'(pos_y);
        abs_z = pos_z[CW-1] ? CW'(-pos_z) : CW'(pos_z);

        s1_valid_next  = s1_valid_reg;
        s1_x_next      = s1_x_reg;
        s1_y_next      = s1_y_reg;
        s1_z_next      = s1_z_reg;
        s1_sqx_next    = s1_sqx_reg;
        s1_sqy_next    = s1_sqy_reg;
        s1_sqz_next    = s1_sqz_reg;
        s1_first_next  = s1_first_reg;
        s1_last_next   = s1_last_reg;
        s1_extend_next = s1_extend_reg;
        s1_empty_next  = s1_empty_reg;

        if (accept)
        begin
            s1_valid_next  = 1'b1;
            s1_x_next      = pos_x;
            s1_y_next      = pos_y;
            s1_z_next      = pos_z;
            s1_sqx_next    = SQ_W'(abs_x) * SQ_W'(abs_x);
            s1_sqy_next    = SQ_W'(abs_y) * SQ_W'(abs_y);
            s1_sqz_next    = SQ_W'(abs_z) * SQ_W'(abs_z);
            s1_first_next  = first_vertex;
            s1_last_next   = last_vertex;
            s1_extend_next = extend_only;
            s1_empty_next  = empty_set;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Stage 2: fold the vertex into the box and the squared maximum.
    always_comb
    begin
        restart = s1_first_reg && !s1_extend_reg;
        if (restart)
        begin
            base_lx = s1_x_reg;
            base_ly = s1_y_reg;
            base_lz = s1_z_reg;
            base_hx = s1_x_reg;
            base_hy = s1_y_reg;
            base_hz = s1_z_reg;
            base_sq = '0;
        end
        else
        begin
            base_lx = low_x_reg;
            base_ly = low_y_reg;
            base_lz = low_z_reg;
            base_hx = high_x_reg;
            base_hy = high_y_reg;
            base_hz = high_z_reg;
            base_sq = max_sq_reg;
        end

        // Three squares of at most 2^(2CW-2) each fit in 2CW bits.
        sq_sum = s1_sqx_reg + s1_sqy_reg + s1_sqz_reg;

        low_x_next  = low_x_reg;
        low_y_next  = low_y_reg;
        low_z_next  = low_z_reg;
        high_x_next = high_x_reg;
        high_y_next = high_y_reg;
        high_z_next = high_z_reg;
        max_sq_next = max_sq_reg;

        if (s1_empty_reg)
        begin
            // Empty set: without extend everything clears, extend keeps the state.
            if (!s1_extend_reg)
            begin
                low_x_next  = '0;
                low_y_next  = '0;
                low_z_next  = '0;
                high_x_next = '0;
                high_y_next = '0;
                high_z_next = '0;
                max_sq_next = '0;
            end
        end
        else
        begin
            low_x_next  = (s1_x_reg < base_lx) ? s1_x_reg : base_lx;
            low_y_next  = (s1_y_reg < base_ly) ? s1_y_reg : base_ly;
            low_z_next  = (s1_z_reg < base_lz) ? s1_z_reg : base_lz;
            high_x_next = (s1_x_reg > base_hx) ? s1_x_reg : base_hx;
            high_y_next = (s1_y_reg > base_hy) ? s1_y_reg : base_hy;
            high_z_next = (s1_z_reg > base_hz) ? s1_z_reg : base_hz;
            max_sq_next = (sq_sum > base_sq) ? sq_sum : base_sq;
        end
    end

    // A finished set goes to the queue with the updated state.
    assign push      = advance && emit;
    assign push_data = {max_sq_next, low_x_next, low_y_next, low_z_next,
                        high_x_next, high_y_next, high_z_next};

    // Stage 1 control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage 1 payload.
    always_ff @(posedge clk)
    begin
        s1_x_reg      <= s1_x_next;
        s1_y_reg      <= s1_y_next;
        s1_z_reg      <= s1_z_next;
        s1_sqx_reg    <= s1_sqx_next;
        s1_sqy_reg    <= s1_sqy_next;
        s1_sqz_reg    <= s1_sqz_next;
        s1_first_reg  <= s1_first_next;
        s1_last_reg   <= s1_last_next;
        s1_extend_reg <= s1_extend_next;
        s1_empty_reg  <= s1_empty_next;
    end

    // Set state, cleared by reset since a stray vertex folds into it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_x_reg  <= '0;
            low_y_reg  <= '0;
            low_z_reg  <= '0;
            high_x_reg <= '0;
            high_y_reg <= '0;
            high_z_reg <= '0;
            max_sq_reg <= '0;
        end
        else if (advance)
        begin
            low_x_reg  <= low_x_next;
            low_y_reg  <= low_y_next;
            low_z_reg  <= low_z_next;
            high_x_reg <= high_x_next;
            high_y_reg <= high_y_next;
            high_z_reg <= high_z_next;
            max_sq_reg <= max_sq_next;
        end
    end

endmodule

@@ rtl/vbr_queue.sv @@
// ----------------------------------------------------------------------------
// vbr_queue
// Two-entry queue of finished sets between the accumulating front end and
// the square root back end.
// ----------------------------------------------------------------------------
module vbr_queue
    import vbr_pkg::*;
#(
    parameter int DATA_W = 192
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output vbr_q_status_t     q_status
);

    logic [1:0][DATA_W-1:0] entry_reg;
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             count_reg, count_next;

    // Occupancy and read side.
    assign q_status.full      = (count_reg == 2'd2);
    assign q_status.not_empty = (count_reg != 2'd0);
    assign pop_data           = entry_reg[rd_ptr_reg];

    // Pointer and count update.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/vbr_back.sv @@
// ----------------------------------------------------------------------------
// vbr_back
// Takes one finished set from the queue, computes the floor square root of
// its squared maximum one result bit per cycle and presents box and radius
// on the result channel.
// ----------------------------------------------------------------------------
module vbr_back
    import vbr_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  vbr_q_status_t                 q_status,
    input  logic [8*COORD_WIDTH-1:0]      pop_data,
    output logic                          pop,
    output logic signed [COORD_WIDTH-1:0] min_x,
    output logic signed [COORD_WIDTH-1:0] min_y,
    output logic signed [COORD_WIDTH-1:0] min_z,
    output logic signed [COORD_WIDTH-1:0] max_x,
    output logic signed [COORD_WIDTH-1:0] max_y,
    output logic signed [COORD_WIDTH-1:0] max_z,
    output logic [COORD_WIDTH-1:0]        radius,
    output logic                          out_valid,
    input  logic                          out_stall
);

    localparam int CW    = COORD_WIDTH;
    localparam int SQ_W  = 2 * COORD_WIDTH;
    localparam int REM_W = COORD_WIDTH + 3;
    localparam int CNT_W = $clog2(COORD_WIDTH);

    vbr_back_state_t      state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SQ_W-1:0]      rad_reg, rad_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [CW-1:0]        root_reg, root_next;
    logic [6*CW-1:0]      box_reg, box_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7*CW-1:0]      out_reg, out_next;

    logic [REM_W-1:0]     rem_shift, trial;
    logic                 fits;
    logic                 out_free;

    // One restoring step: bring down two radicand bits, try a one bit.
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[SQ_W-1 -: 2]};
        trial     = REM_W'({root_reg, 2'b01});
        fits      = (rem_shift >= trial);
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == BK_IDLE) && q_status.not_empty;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        box_next       = box_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    rad_next   = pop_data[8*CW-1 -: SQ_W];
                    box_next   = pop_data[6*CW-1:0];
                    rem_next   = '0;
                    root_next  = '0;
                    count_next = CNT_W'(COORD_WIDTH - 1);
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                rad_next  = {rad_reg[SQ_W-3:0], 2'b00};
                rem_next  = fits ? (rem_shift - trial) : rem_shift;
                root_next = {root_reg[CW-2:0], fits};
                if (count_reg == '0)
                begin
                    state_next = BK_HOLD;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            BK_HOLD:
            begin
                // Hand over once the output register is empty or drains.
                if (out_free)
                begin
                    out_next       = {box_reg, root_reg};
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        rad_reg   <= rad_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        box_reg   <= box_next;
        out_reg   <= out_next;
    end

    // Result channel.
    assign out_valid = out_valid_reg;
    assign min_x     = out_reg[7*CW-1 -: CW];
    assign min_y     = out_reg[6*CW-1 -: CW];
    assign min_z     = out_reg[5*CW-1 -: CW];
    assign max_x     = out_reg[4*CW-1 -: CW];
    assign max_y     = out_reg[3*CW-1 -: CW];
    assign max_z     = out_reg[2*CW-1 -: CW];
    assign radius    = out_reg[CW-1:0];

endmodule

@@ tb/vertex_bounds_and_radius_tb.sv @@
// ----------------------------------------------------------------------------
// vertex_bounds_and_radius_tb
// Self-checking bench for the vertex bounds and radius block. Vertex beats
// are queued up front, driven with random gaps except in the last profile,
// and run through a software model of the box and squared-length tracker. Each result beat is compared
// field by field with the oldest predicted box.
// ----------------------------------------------------------------------------
module vertex_bounds_and_radius_tb;

    localparam int COORD_W = 24;
    localparam int SQ_W = 2 * COORD_W;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 64;

    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    // Idle profiles: random gaps on both sides, then swapped, then none.
    localparam int PH_SEND_LIGHT = 0;
    localparam int PH_SEND_HEAVY = 1;
    localparam int PH_NO_IDLE = 2;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic is_first;
        logic is_last;
        logic grow;
        logic no_verts;
        bit   wait_drain;
        int   phase;
    } vertex_beat_t;

    typedef struct {
        logic signed [COORD_W-1:0] lo_x;
        logic signed [COORD_W-1:0] lo_y;
        logic signed [COORD_W-1:0] lo_z;
        logic signed [COORD_W-1:0] hi_x;
        logic signed [COORD_W-1:0] hi_y;
        logic signed [COORD_W-1:0] hi_z;
        logic [COORD_W-1:0]        rad;
    } box_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic signed [COORD_W-1:0] pos_x = '0;
    logic signed [COORD_W-1:0] pos_y = '0;
    logic signed [COORD_W-1:0] pos_z = '0;
    logic first_vertex = 1'b0;
    logic last_vertex = 1'b0;
    logic extend_only = 1'b0;
    logic empty_set = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
    logic [COORD_W-1:0] radius;
    logic out_valid;
    logic out_stall = 1'b0;

    // Tracker state of the predictor.
    logic signed [COORD_W-1:0] lo_x = '0;
    logic signed [COORD_W-1:0] lo_y = '0;
    logic signed [COORD_W-1:0] lo_z = '0;
    logic signed [COORD_W-1:0] hi_x = '0;
    logic signed [COORD_W-1:0] hi_y = '0;
    logic signed [COORD_W-1:0] hi_z = '0;
    logic [SQ_W-1:0] sq_peak = '0;

    vertex_beat_t pending_beats[$];
    box_result_t expected_boxes[$];
    vertex_beat_t sent_beat;
    box_result_t next_box;
    box_result_t want_box;
    bit box_due;
    int build_phase = PH_SEND_LIGHT;
    int rx_stall_pct = 47;
    int total_beats = 0;
    int beats_accepted = 0;
    int mismatch_count = 0;
    int unsigned cycle_count = 0;

    vertex_bounds_and_radius #(
        .COORD_WIDTH(COORD_W)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .first_vertex(first_vertex),
        .last_vertex(last_vertex),
        .extend_only(extend_only),
        .empty_set(empty_set),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .min_x(min_x),
        .min_y(min_y),
        .min_z(min_z),
        .max_x(max_x),
        .max_y(max_y),
        .max_z(max_z),
        .radius(radius),
        .out_valid(out_valid),
        .out_stall(out_stall)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Exact squared length; each square fits, so only the sum needs unsigned.
    function automatic logic [SQ_W-1:0] square_len(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b,
                                                   input logic signed [COORD_W-1:0] c);
        logic signed [SQ_W-1:0] wa;
        logic signed [SQ_W-1:0] wb;
        logic signed [SQ_W-1:0] wc;
        wa = a;
        wb = b;
        wc = c;
        square_len = $unsigned(wa * wa) + $unsigned(wb * wb) + $unsigned(wc * wc);
    endfunction

    // Floor square root, settling one root bit at a time from the top.
    function automatic logic [COORD_W-1:0] floor_root(input logic [SQ_W-1:0] n);
        logic [COORD_W-1:0] root;
        logic [SQ_W-1:0] trial;
        root = '0;
        for (int i = COORD_W - 1; i >= 0; i--)
        begin
            trial = {{COORD_W{1'b0}}, root | (COORD_W'(1) << i)};
            if (trial * trial <= n)
                root = root | (COORD_W'(1) << i);
        end
        floor_root = root;
    endfunction

    // Fold one beat into the tracked box and report whether a box is due.
    function automatic void track_bounds(input vertex_beat_t b, output bit emits,
                                         output box_result_t r);
        logic [SQ_W-1:0] len_sq;
        if (b.no_verts)
        begin
            if (!b.grow)
            begin
                lo_x = '0; lo_y = '0; lo_z = '0;
                hi_x = '0; hi_y = '0; hi_z = '0;
                sq_peak = '0;
            end
            emits = 1'b1;
        end
        else
        begin
            if (b.is_first && !b.grow)
            begin
                lo_x = b.x; hi_x = b.x;
                lo_y = b.y; hi_y = b.y;
                lo_z = b.z; hi_z = b.z;
                sq_peak = '0;
            end
            if (b.x < lo_x) lo_x = b.x;
            if (b.y < lo_y) lo_y = b.y;
            if (b.z < lo_z) lo_z = b.z;
            if (b.x > hi_x) hi_x = b.x;
            if (b.y > hi_y) hi_y = b.y;
            if (b.z > hi_z) hi_z = b.z;
            len_sq = square_len(b.x, b.y, b.z);
            if (len_sq > sq_peak)
                sq_peak = len_sq;
            emits = b.is_last;
        end
        r.lo_x = lo_x; r.lo_y = lo_y; r.lo_z = lo_z;
        r.hi_x = hi_x; r.hi_y = hi_y; r.hi_z = hi_z;
        r.rad = floor_root(sq_peak);
    endfunction

    function automatic int send_idle_pct(input int phase);
        case (phase)
            PH_SEND_LIGHT: send_idle_pct = 29;
            PH_SEND_HEAVY: send_idle_pct = 47;
            default:       send_idle_pct = 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input int phase);
        case (phase)
            PH_SEND_LIGHT: recv_stall_pct = 47;
            PH_SEND_HEAVY: recv_stall_pct = 29;
            default:       recv_stall_pct = 0;
        endcase
    endfunction

    // Coordinates lean on the extremes and on values near zero.
    function automatic logic signed [COORD_W-1:0] pick_coord();
        logic signed [COORD_W-1:0] v;
        case ($urandom_range(9))
            0: v = C_MIN;
            1: v = C_MAX;
            2: v = COORD_W'($urandom_range(2)) - COORD_W'(1);
            3, 4: v = COORD_W'($urandom_range(2047)) - COORD_W'(1024);
            default: v = COORD_W'($urandom);
        endcase
        pick_coord = v;
    endfunction

    task automatic report_mismatch(input string what, input logic [SQ_W-1:0] got,
                                   input logic [SQ_W-1:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_beat(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic signed [COORD_W-1:0] z,
                            input logic f, input logic l, input logic g,
                            input logic e, input bit hold);
        vertex_beat_t b;
        b.x = x;
        b.y = y;
        b.z = z;
        b.is_first = f;
        b.is_last = l;
        b.grow = g;
        b.no_verts = e;
        b.wait_drain = hold;
        b.phase = build_phase;
        pending_beats.push_back(b);
    endtask

    // Mostly well-formed sets with random content, the rest loose or empty-set beats.
    task automatic add_random_traffic(input int count);
        int stop;
        int n;
        int start;
        start = pending_beats.size();
        stop = start + count;
        while (pending_beats.size() < stop)
        begin
            if ($urandom_range(99) < 85)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(32, 8) : $urandom_range(6, 1);
                for (int k = 0; k < n; k++)
                    add_beat(pick_coord(), pick_coord(), pick_coord(), k == 0, k == n - 1,
                             (k == 0) ? ($urandom_range(3) == 0) : $urandom_range(1),
                             1'b0, $urandom_range(99) == 0);
            end
            else if ($urandom_range(4) < 2)
            begin
                add_beat(pick_coord(), pick_coord(), pick_coord(), $urandom_range(1),
                         $urandom_range(1), $urandom_range(1), 1'b1, 1'b0);
            end
            else
            begin
                add_beat(pick_coord(), pick_coord(), pick_coord(), $urandom_range(1),
                         $urandom_range(1), $urandom_range(1), 1'b0, 1'b0);
            end
        end
        // Each profile opens once the previous results have all drained.
        pending_beats[start].wait_drain = 1'b1;
    endtask

    // Stimulus, reset and end of run.
    initial
    begin
        build_phase = PH_SEND_LIGHT;
        // Loose beats right after reset fold into the zero box.
        add_beat(24'sd1280, -24'sd768, 24'sd256, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_beat(C_MAX, C_MAX, C_MAX, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        // One-vertex set at the most negative corner: largest radius.
        add_beat(C_MIN, C_MIN, C_MIN, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        // Restarted set; the grow bit on a middle beat must do nothing.
        add_beat(C_MAX, C_MIN, 24'sd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_beat(-24'sd1, 24'sd1, 24'sd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        add_beat(C_MIN, C_MAX, -24'sd1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        // Empty sets: repeat stored bounds, then clear, then repeat the zeros.
        add_beat(24'sd5, 24'sd6, 24'sd7, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        add_beat(C_MAX, C_MIN, C_MAX, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
        add_beat(C_MIN, C_MAX, C_MIN, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        // Growing sets keep the stored box and squared maximum.
        add_beat(24'sd0, 24'sd0, 24'sd256, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        add_beat(-24'sd256, 24'sd512, -24'sd1024, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        add_beat(24'sd7, 24'sd7, 24'sd7, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        add_beat(24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        add_beat(24'sd1, -24'sd1, 24'sd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_beat(-24'sd1, 24'sd1, -24'sd1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        add_beat(C_MAX, C_MAX, C_MAX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_beat(24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
        add_beat(C_MIN, 24'sd0, C_MAX, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        add_beat(C_MIN, C_MIN, C_MIN, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);

        add_random_traffic(480);
        build_phase = PH_SEND_HEAVY;
        add_random_traffic(500);
        build_phase = PH_NO_IDLE;
        add_random_traffic(500);
        total_beats = pending_beats.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait (beats_accepted == total_beats);
        wait (expected_boxes.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Driver: predict on each accepted beat, then present the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_bounds(sent_beat, box_due, next_box);
                if (box_due)
                    expected_boxes.push_back(next_box);
                beats_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_beats.size() > 0
                    && !(pending_beats[0].wait_drain && expected_boxes.size() != 0)
                    && $urandom_range(99) >= send_idle_pct(pending_beats[0].phase))
                begin
                    sent_beat = pending_beats.pop_front();
                    pos_x <= sent_beat.x;
                    pos_y <= sent_beat.y;
                    pos_z <= sent_beat.z;
                    first_vertex <= sent_beat.is_first;
                    last_vertex <= sent_beat.is_last;
                    extend_only <= sent_beat.grow;
                    empty_set <= sent_beat.no_verts;
                    in_valid <= 1'b1;
                    rx_stall_pct <= recv_stall_pct(sent_beat.phase);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result beat against the oldest box.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_boxes.size() == 0)
                begin
                    report_mismatch("unexpected result beat", '0, '0);
                end
                else
                begin
                    want_box = expected_boxes.pop_front();
                    if (min_x !== want_box.lo_x) report_mismatch("min_x", min_x, want_box.lo_x);
                    if (min_y !== want_box.lo_y) report_mismatch("min_y", min_y, want_box.lo_y);
                    if (min_z !== want_box.lo_z) report_mismatch("min_z", min_z, want_box.lo_z);
                    if (max_x !== want_box.hi_x) report_mismatch("max_x", max_x, want_box.hi_x);
                    if (max_y !== want_box.hi_y) report_mismatch("max_y", max_y, want_box.hi_y);
                    if (max_z !== want_box.hi_z) report_mismatch("max_z", max_z, want_box.hi_z);
                    if (radius !== want_box.rad) report_mismatch("radius", radius, want_box.rad);
                end
            end
            out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Watchdog on a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
